// ----- sv/sorted_key_value_table_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key-value table
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SKVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted key-value table check failed");

// antecedent implies consequent in the next cycle
`define SKVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted key-value table check failed");

`endif

// ----- sv/skvt_pkg.sv -----
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared codes and types of the sorted key-value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int RANK_W   = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPSERT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET_KEY  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_GET_RANK = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANK    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic apply;
  } ctl_t;

endpackage

// ----- sv/skvt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skvt_ctrl
// Command sequencer: load, compare, apply, then result strobe.
// ----------------------------------------------------------------------------
module skvt_ctrl
  import skvt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output ctl_t ctl,
  output logic out_valid
);

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctl.apply;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctl.compare = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        ctl.apply = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/skvt_datapath.sv -----
// ----------------------------------------------------------------------------
// skvt_datapath
// Row of compare-and-shift cells, command decode and result registers.
// ----------------------------------------------------------------------------
module skvt_datapath
  import skvt_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ctl_t                               ctl,
  input  logic [CMD_W-1:0]                   in_cmd,
  input  logic [KEY_WIDTH-1:0]               in_key,
  input  logic [VALUE_WIDTH-1:0]             in_value,
  input  logic [RANK_W-1:0]                  in_rank,
  output logic                               out_ok,
  output logic [STATUS_W-1:0]                out_status,
  output logic [KEY_WIDTH-1:0]               out_key,
  output logic [VALUE_WIDTH-1:0]             out_value,
  output logic [$clog2(CAPACITY+1)-1:0]      out_entry_count
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

  logic [CMD_W-1:0]       cmd_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [RANK_W-1:0]      rank_r;

  logic [KEY_WIDTH-1:0]   keys_r [CAPACITY];
  logic [VALUE_WIDTH-1:0] vals_r [CAPACITY];
  logic [KEY_WIDTH-1:0]   keys_nxt [CAPACITY];
  logic [VALUE_WIDTH-1:0] vals_nxt [CAPACITY];
  logic [CW-1:0]          count_r, count_nxt;

  logic [CAPACITY-1:0] lt, eq, lt_r, eq_r, ge, ge_prev;

  logic                   ok_nxt, ok_r;
  logic [STATUS_W-1:0]    status_nxt, status_r;
  logic [KEY_WIDTH-1:0]   okey_nxt, okey_r;
  logic [VALUE_WIDTH-1:0] oval_nxt, oval_r, hit_val;
  logic [CW-1:0]          ocount_r;
  logic                   do_ins, do_upd, do_del, hit, full, rank_ok;
  logic [IW-1:0]          rank_idx;

  assign ge = ~lt_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   valid;
    logic [KEY_WIDTH-1:0]   prev_key, next_key;
    logic [VALUE_WIDTH-1:0] prev_val, next_val;

    assign valid = CW'(i) < count_r;
    assign lt[i] = valid && (keys_r[i] < key_r);
    assign eq[i] = valid && (keys_r[i] == key_r);

    if (i == 0) begin : g_first
      assign ge_prev[i] = 1'b0;
      assign prev_key   = key_r;
      assign prev_val   = value_r;
    end else begin : g_mid
      assign ge_prev[i] = ge[i-1];
      assign prev_key   = keys_r[i-1];
      assign prev_val   = vals_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = keys_r[i];
      assign next_val = vals_r[i];
    end else begin : g_inner
      assign next_key = keys_r[i+1];
      assign next_val = vals_r[i+1];
    end

    always_comb begin
      keys_nxt[i] = keys_r[i];
      vals_nxt[i] = vals_r[i];
      if (do_ins) begin
        if (ge_prev[i]) begin
          keys_nxt[i] = prev_key;
          vals_nxt[i] = prev_val;
        end else if (ge[i]) begin
          keys_nxt[i] = key_r;
          vals_nxt[i] = value_r;
        end
      end else if (do_del) begin
        if (ge[i]) begin
          keys_nxt[i] = next_key;
          vals_nxt[i] = next_val;
        end
      end else if (do_upd && eq_r[i]) begin
        vals_nxt[i] = value_r;
      end
    end
  end

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_val = hit_val | (eq_r[i] ? vals_r[i] : '0);
    end
  end

  assign hit      = |eq_r;
  assign full     = count_r == CW'(CAPACITY);
  assign rank_ok  = CMPW'(rank_r) < CMPW'(count_r);
  assign rank_idx = IW'(rank_r);

  always_comb begin
    ok_nxt     = 1'b0;
    status_nxt = ST_DONE;
    okey_nxt   = key_r;
    oval_nxt   = '0;
    do_ins     = 1'b0;
    do_upd     = 1'b0;
    do_del     = 1'b0;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (hit) status_nxt = ST_PRESENT;
        else if (full) status_nxt = ST_FULL;
        else begin
          do_ins = 1'b1;
          ok_nxt = 1'b1;
        end
      end
      CMD_UPDATE: begin
        if (!hit) status_nxt = ST_ABSENT;
        else begin
          do_upd = 1'b1;
          ok_nxt = 1'b1;
        end
      end
      CMD_UPSERT: begin
        if (hit) begin
          do_upd = 1'b1;
          ok_nxt = 1'b1;
        end else if (full) status_nxt = ST_FULL;
        else begin
          do_ins = 1'b1;
          ok_nxt = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (!hit) status_nxt = ST_ABSENT;
        else begin
          do_del = 1'b1;
          ok_nxt = 1'b1;
        end
      end
      CMD_GET_KEY: begin
        if (!hit) status_nxt = ST_ABSENT;
        else begin
          oval_nxt = hit_val;
          ok_nxt   = 1'b1;
        end
      end
      CMD_GET_RANK: begin
        if (!rank_ok) status_nxt = ST_RANK;
        else begin
          okey_nxt = keys_r[rank_idx];
          oval_nxt = vals_r[rank_idx];
          ok_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CW'(1);
    else if (do_del) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.apply) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_cmd;
      key_r   <= in_key;
      value_r <= in_value;
      rank_r  <= in_rank;
    end
    if (ctl.compare) begin
      lt_r <= lt;
      eq_r <= eq;
    end
    if (ctl.apply) begin
      keys_r   <= keys_nxt;
      vals_r   <= vals_nxt;
      ok_r     <= ok_nxt;
      status_r <= status_nxt;
      okey_r   <= okey_nxt;
      oval_r   <= oval_nxt;
      ocount_r <= count_nxt;
    end
  end

  assign out_ok          = ok_r;
  assign out_status      = status_r;
  assign out_key         = okey_r;
  assign out_value       = oval_r;
  assign out_entry_count = ocount_r;

endmodule

// ----- sv/sorted_key_value_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Key-value table held in ascending key order with unique keys.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low: in_cmd selects
// insert, update, insert-or-update, erase, get by key or get by rank, with
// in_key, in_value and in_rank as operands.
// Each command gives one result, shown for one cycle with out_valid high:
// out_ok, out_status, out_key, out_value and out_entry_count (the count
// after the command). The receiver cannot stall; a result must be taken
// in the cycle it is shown.
// Sequence: start is sampled, the cell row compares the key in the next
// cycle, the shift or update is applied after that, and out_valid rises
// after the apply. A new command is taken only after the last one: busy
// falls in the cycle out_valid is high, so the next start can be taken
// there. The pace is set by the registered compare of all cells followed
// by the shift step of the same row.
// Reset empties the table at once (count to zero); no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_value_table_core
  import skvt_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [CMD_W-1:0]              in_cmd,
  input  logic [KEY_WIDTH-1:0]          in_key,
  input  logic [VALUE_WIDTH-1:0]        in_value,
  input  logic [RANK_W-1:0]             in_rank,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [STATUS_W-1:0]           out_status,
  output logic [KEY_WIDTH-1:0]          out_key,
  output logic [VALUE_WIDTH-1:0]        out_value,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_count
);

  ctl_t ctl;

  skvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .ctl       (ctl),
    .out_valid (out_valid)
  );

  skvt_datapath #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_value        (in_value),
    .in_rank         (in_rank),
    .out_ok          (out_ok),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_value       (out_value),
    .out_entry_count (out_entry_count)
  );

endmodule

// ----- sv/skvt_checker.sv -----
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks of the sorted key-value table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_core_macros.svh"

module skvt_checker
  import skvt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_ok,
  input logic [STATUS_W-1:0]           out_status,
  input logic [$clog2(CAPACITY+1)-1:0] out_entry_count
);

  `SKVT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SKVT_ASSERT_NOW(a_result_idle, out_valid, !busy)
  `SKVT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `SKVT_ASSERT_NOW(a_ok_done, out_valid && out_ok, out_status == ST_DONE)
  `SKVT_ASSERT_NOW(a_count_cap, out_valid, out_entry_count <= ($clog2(CAPACITY+1))'(CAPACITY))

endmodule

bind sorted_key_value_table_core skvt_checker #(
  .CAPACITY (CAPACITY)
) u_skvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_ok          (out_ok),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench of sorted_key_value_table_core: directed corner commands, random
// streams and a full-table fill and drain, checked by a behavioral table model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skvt_pkg::*;

  localparam int CAP = 64;

  typedef struct {
    logic        ok;
    logic [2:0]  status;
    logic [31:0] key;
    logic [31:0] value;
    logic [6:0]  count;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic [5:0]  in_rank = '0;
  logic        out_valid, out_ok;
  logic [2:0]  out_status;
  logic [31:0] out_key, out_value;
  logic [6:0]  out_entry_count;

  logic [31:0] tbl_key [CAP];
  logic [31:0] tbl_val [CAP];
  int          tbl_count;
  answer_t     pending[$];
  int          errors = 0;
  int          sent = 0;
  int          send_idle_pct = 0;
  int          results_seen = 0;

  sorted_key_value_table_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key(in_key), .in_value(in_value), .in_rank(in_rank),
    .out_valid(out_valid), .out_ok(out_ok), .out_status(out_status),
    .out_key(out_key), .out_value(out_value), .out_entry_count(out_entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic answer_t table_apply(logic [2:0] c, logic [31:0] k,
                                          logic [31:0] v, logic [5:0] r);
    answer_t a;
    int pos;
    bit hit;
    a.ok = 0; a.status = ST_DONE; a.key = k; a.value = '0;
    pos = 0;
    while (pos < tbl_count && tbl_key[pos] < k) pos++;
    hit = pos < tbl_count && tbl_key[pos] == k;
    case (c)
      CMD_INSERT, CMD_UPSERT: begin
        if (hit && c == CMD_INSERT) a.status = ST_PRESENT;
        else if (hit) begin
          tbl_val[pos] = v; a.ok = 1;
        end else if (tbl_count >= CAP) a.status = ST_FULL;
        else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1]; tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[pos] = k; tbl_val[pos] = v; tbl_count++; a.ok = 1;
        end
      end
      CMD_UPDATE: begin
        if (!hit) a.status = ST_ABSENT;
        else begin
          tbl_val[pos] = v; a.ok = 1;
        end
      end
      CMD_ERASE: begin
        if (!hit) a.status = ST_ABSENT;
        else begin
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1]; tbl_val[i] = tbl_val[i+1];
          end
          tbl_count--; a.ok = 1;
        end
      end
      CMD_GET_KEY: begin
        if (!hit) a.status = ST_ABSENT;
        else begin
          a.value = tbl_val[pos]; a.ok = 1;
        end
      end
      CMD_GET_RANK: begin
        if (r >= tbl_count) a.status = ST_RANK;
        else begin
          a.key = tbl_key[r]; a.value = tbl_val[r]; a.ok = 1;
        end
      end
      default: ;
    endcase
    a.count = 7'(tbl_count);
    return a;
  endfunction

  task automatic send_cmd(logic [2:0] c, logic [31:0] k, logic [31:0] v, logic [5:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_cmd <= c; in_key <= k; in_value <= v; in_rank <= r; start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending.push_back(table_apply(c, k, v, r));
    sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with no expectation");
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_ok !== e.ok) begin
          $error("ok exp %0d got %0d", e.ok, out_ok); errors++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_key !== e.key) begin
          $error("key exp %h got %h", e.key, out_key); errors++;
        end
        if (out_value !== e.value) begin
          $error("value exp %h got %h", e.value, out_value); errors++;
        end
        if (out_entry_count !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, out_entry_count); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0 && tbl_count > 0) return tbl_key[$urandom_range(tbl_count - 1)];
    if (sel < 6) return 32'($urandom_range(80));
    if (sel == 6) return 32'hFFFF_FFFF - $urandom_range(3);
    return $urandom;
  endfunction

  task automatic test_corners();
    send_cmd(CMD_GET_KEY, 32'd5, '0, '0);
    send_cmd(CMD_GET_RANK, 32'd7, '0, 6'd0);
    send_cmd(CMD_UPDATE, 32'd5, 32'd1, '0);
    send_cmd(CMD_ERASE, 32'd5, '0, '0);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_INSERT, 32'd0, 32'd0, '0);
    send_cmd(CMD_INSERT, 32'd0, 32'd9, '0);
    send_cmd(CMD_UPSERT, 32'd0, 32'hA5A5_5A5A, '0);
    send_cmd(CMD_UPSERT, 32'h8000_0000, 32'h1234_5678, '0);
    send_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 32'h5A5A_A5A5, '0);
    send_cmd(CMD_GET_KEY, 32'hFFFF_FFFF, '0, '0);
    send_cmd(CMD_GET_RANK, '0, '0, 6'd2);
    send_cmd(CMD_GET_RANK, '0, '0, 6'd3);
    send_cmd(CMD_GET_RANK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_cmd(3'd6, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 6'd63);
    send_cmd(3'd7, 32'h1234_0000, 32'd1, 6'd1);
    send_cmd(CMD_ERASE, 32'h8000_0000, '0, '0);
    send_cmd(CMD_ERASE, 32'h8000_0000, '0, '0);
  endtask

  task automatic test_full_table();
    while (tbl_count < CAP) send_cmd(CMD_INSERT, $urandom, $urandom, '0);
    send_cmd(CMD_INSERT, 32'h7777_7777, 32'd1, '0);
    send_cmd(CMD_UPSERT, 32'h7777_7778, 32'd1, '0);
    send_cmd(CMD_UPSERT, tbl_key[10], 32'd3, '0);
    send_cmd(CMD_GET_RANK, '0, '0, 6'd63);
    while (tbl_count > 0) send_cmd(CMD_ERASE, tbl_key[$urandom_range(tbl_count - 1)], '0, '0);
  endtask

  task automatic test_random(int n);
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      c = 3'($urandom_range(7));
      if (c > CMD_GET_RANK && $urandom_range(3) != 0) c = CMD_UPSERT;
      send_cmd(c, pick_key(), $urandom, 6'($urandom_range(63)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tbl_count = 0;
    test_corners();
    send_idle_pct = 14;
    test_random(80);
    send_idle_pct = 61;
    test_full_table();
    test_random(80);
    send_idle_pct = 0;
    test_random(90);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d commands, checked %0d results incl. full-table and corner cases.",
             sent, results_seen);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
